// ===== design/cached_trilinear_grid_sampler_unit_macros.svh =====
// Assertion macros for the cached trilinear grid sampler.
// Used by the port checker; no other dependencies.
`ifndef CACHED_TRILINEAR_GRID_SAMPLER_UNIT_MACROS_SVH
`define CACHED_TRILINEAR_GRID_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define CTGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctgs assertion failed");

// next-cycle implication
`define CTGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctgs assertion failed");

`endif

// ===== design/ctgs_pkg.sv =====
// Shared types, constants and helpers of the cached trilinear grid sampler.
// No dependencies.
package ctgs_pkg;

    localparam int GRID_X_DEF      = 64;
    localparam int GRID_Y_DEF      = 64;
    localparam int GRID_Z_DEF      = 64;
    localparam int MAX_DOMAINS_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [31:0] ORIGIN_RST = 32'sd0;
    localparam logic [31:0]        SCALE_RST  = 32'd65536;
    localparam logic [30:0]        BIAS_RST   = 31'd196608;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_SCALE_X  = 3'd3,
        CFG_SCALE_Y  = 3'd4,
        CFG_SCALE_Z  = 3'd5,
        CFG_BIAS     = 3'd6
    } ctgs_cfg_idx_t;

    typedef struct packed {
        logic              cmd;
        logic [17:0]       load_index;
        logic [31:0]       load_value;
        logic [2:0][31:0]  u;
        logic              new_domain;
        logic [2:0]        slot;
    } ctgs_job_t;

    typedef struct packed {
        logic              in_grid;
        logic [2:0][31:0]  low;
        logic [2:0][31:0]  high;
        logic [7:0][31:0]  corner;
    } ctgs_slot_t;

    function automatic logic signed [31:0] ctgs_sat32(input logic signed [57:0] v);
        logic signed [57:0] vmax;
        logic signed [57:0] vmin;
        logic signed [31:0] r;
        vmax = {26'b0, 32'h7FFF_FFFF};
        vmin = {{26{1'b1}}, 32'h8000_0000};
        if (v > vmax)
            r = 32'sh7FFF_FFFF;
        else if (v < vmin)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/ctgs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ctgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/ctgs_fifo.sv =====
// Short item queue between the front and back parts of the sampler.
// Depends on ctgs_pkg.
module ctgs_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctgs_pkg::ctgs_job_t push_job,
    output logic              full,
    input  logic              pop,
    output ctgs_pkg::ctgs_job_t head,
    output logic              empty
);
    import ctgs_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ctgs_job_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg, wp_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push && !full)
        begin
            wp_next  = (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rp_next  = (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
            cnt_next = cnt_reg + 1'b1;
        else if (!(push && !full) && (pop && !empty))
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end
endmodule

// ===== design/ctgs_front.sv =====
// Front part: configuration registers, item intake and mapping of points to grid units.
// Depends on ctgs_pkg; feeds ctgs_fifo.
module ctgs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [17:0]        load_index,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               new_domain,
    input  logic [2:0]         slot,
    output logic [30:0]        bias,
    output logic               q_push,
    output ctgs_pkg::ctgs_job_t q_job,
    input  logic               q_full
);
    import ctgs_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_PUSH = 3'b100
    } ctgs_fstate_t;

    ctgs_fstate_t       state_reg, state_next;
    ctgs_job_t          job_reg, job_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [2:0][32:0]   mag_reg, mag_next;
    logic [2:0]         neg_reg, neg_next;
    logic [48:0]        hi_reg, hi_next;
    logic [47:0]        lo_reg, lo_next;
    logic signed [31:0] origin_reg [3];
    logic [31:0]        scale_reg [3];
    logic [30:0]        bias_reg;

    logic [2:0][31:0]   pos_a;
    logic signed [33:0] diff;
    logic [48:0]        lo_round;
    logic [49:0]        usum;
    logic [31:0]        u_c;
    logic [1:0]         axis_out;

    assign pos_a     = {pos_z, pos_y, pos_x};
    assign in_stall  = (state_reg != F_IDLE);
    assign cfg_ready = 1'b1;
    assign bias      = bias_reg;
    assign q_push    = (state_reg == F_PUSH);
    assign q_job     = job_reg;
    assign axis_out  = cnt_reg - 2'd1;

    always_comb
    begin
        lo_round = {1'b0, lo_reg} + (neg_reg[axis_out] ? 49'h0FFFF : 49'h0);
        usum     = {1'b0, hi_reg} + {17'b0, lo_round[48:16]};
        if (!neg_reg[axis_out])
            u_c = (usum > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : usum[31:0];
        else
            u_c = (usum > 50'h8000_0000) ? 32'h8000_0000 : (32'h0 - usum[31:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        diff       = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    job_next.cmd        = cmd;
                    job_next.load_index = load_index;
                    job_next.load_value = load_value;
                    job_next.u          = '0;
                    job_next.new_domain = new_domain;
                    job_next.slot       = slot;
                    for (int d = 0; d < 3; d++)
                    begin
                        diff = $signed({{2{pos_a[d][31]}}, pos_a[d]})
                             - $signed({{2{origin_reg[d][31]}}, origin_reg[d]});
                        neg_next[d] = diff[33];
                        mag_next[d] = diff[33] ? 33'(-diff) : diff[32:0];
                    end
                    cnt_next   = '0;
                    state_next = (cmd == CMD_QUERY) ? F_CALC : F_PUSH;
                end
            end
            F_CALC:
            begin
                if (cnt_reg != 2'd3)
                begin
                    hi_next = 49'(mag_reg[cnt_reg][32:16] * scale_reg[cnt_reg]);
                    lo_next = 48'(mag_reg[cnt_reg][15:0] * scale_reg[cnt_reg]);
                end
                if (cnt_reg != 2'd0)
                begin
                    job_next.u[axis_out] = u_c;
                end
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            for (int d = 0; d < 3; d++)
            begin
                origin_reg[d] <= ORIGIN_RST;
                scale_reg[d]  <= SCALE_RST;
            end
            bias_reg <= BIAS_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid)
            begin
                unique case (ctgs_cfg_idx_t'(cfg_index))
                    CFG_ORIGIN_X: origin_reg[0] <= cfg_data;
                    CFG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                    CFG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                    CFG_SCALE_X:  scale_reg[0]  <= cfg_data;
                    CFG_SCALE_Y:  scale_reg[1]  <= cfg_data;
                    CFG_SCALE_Z:  scale_reg[2]  <= cfg_data;
                    CFG_BIAS:     bias_reg      <= cfg_data[30:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end
endmodule

// ===== design/ctgs_back.sv =====
// Back part: voxel store, per-domain cell cache, cell refill and trilinear blend.
// Depends on ctgs_pkg and ctgs_ram; takes items from ctgs_fifo.
module ctgs_back #(
    parameter int GRID_X      = ctgs_pkg::GRID_X_DEF,
    parameter int GRID_Y      = ctgs_pkg::GRID_Y_DEF,
    parameter int GRID_Z      = ctgs_pkg::GRID_Z_DEF,
    parameter int MAX_DOMAINS = ctgs_pkg::MAX_DOMAINS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                q_pop,
    input  ctgs_pkg::ctgs_job_t q_head,
    input  logic [30:0]         bias,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  field_value,
    output logic [2:0]          slot_used,
    output logic                inside_grid
);
    import ctgs_pkg::*;

    localparam int STORE = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(STORE);
    localparam int SW    = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam int TW    = $clog2(MAX_DOMAINS + 1);
    localparam int VXW   = $clog2(GRID_X);
    localparam int VYW   = $clog2(GRID_Y);
    localparam int VZW   = $clog2(GRID_Z);
    localparam int VMW   = (VXW > VYW) ? ((VXW > VZW) ? VXW : VZW)
                                       : ((VYW > VZW) ? VYW : VZW);
    localparam int SLW   = $bits(ctgs_slot_t);
    localparam logic [AW-1:0] DY = AW'(GRID_X);
    localparam logic [AW-1:0] DZ = AW'(GRID_X * GRID_Y);
    localparam logic signed [31:0] TOP [3] = '{32'((GRID_X - 1) * 65536),
                                               32'((GRID_Y - 1) * 65536),
                                               32'((GRID_Z - 1) * 65536)};
    localparam logic [VMW-1:0] VTOP [3] = '{VMW'(GRID_X - 1), VMW'(GRID_Y - 1),
                                            VMW'(GRID_Z - 1)};
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;

    typedef enum logic [7:0] {
        B_IDLE  = 8'b0000_0001,
        B_LOOK  = 8'b0000_0010,
        B_ADDR  = 8'b0000_0100,
        B_OFS   = 8'b0000_1000,
        B_READ  = 8'b0001_0000,
        B_WRITE = 8'b0010_0000,
        B_MUL   = 8'b0100_0000,
        B_DONE  = 8'b1000_0000
    } ctgs_bstate_t;

    ctgs_bstate_t         state_reg, state_next;
    ctgs_job_t            job_reg, job_next;
    logic [SW-1:0]        s_reg, s_next;
    logic [2:0]           s3_reg, s3_next;
    logic [TW-1:0]        taken_reg, taken_next;
    logic [MAX_DOMAINS-1:0] filled_reg, filled_next;
    logic                 inside_reg, inside_next;
    logic [2:0][31:0]     low_reg, low_next;
    logic [2:0][31:0]     high_reg, high_next;
    logic [7:0][31:0]     corner_reg, corner_next;
    logic [VMW-1:0]       vox_reg [3];
    logic [VMW-1:0]       vox_next [3];
    logic [AW-1:0]        mid_reg, mid_next;
    logic [AW-1:0]        ofs_reg, ofs_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [16:0]          w_reg [3];
    logic [16:0]          w_next [3];
    logic signed [18:0]   wt_reg [4];
    logic signed [18:0]   wt_next [4];
    logic signed [56:0]   prod_reg, prod_next;
    logic signed [53:0]   acc_reg [2];
    logic signed [53:0]   acc_next [2];
    logic signed [56:0]   bl_reg, bl_next;
    logic signed [31:0]   res_reg, res_next;
    logic                 ov_reg, ov_next;
    logic signed [31:0]   ofv_reg, ofv_next;
    logic [2:0]           osl_reg, osl_next;
    logic                 oin_reg, oin_next;

    logic                 vox_we;
    logic [AW-1:0]        vox_waddr;
    logic [AW-1:0]        vox_raddr;
    logic [31:0]          vox_rdata;
    logic                 slot_we;
    logic [SW-1:0]        slot_raddr;
    ctgs_slot_t           slot_wdata;
    logic [SLW-1:0]       slot_rdata;

    ctgs_slot_t           ent;
    logic [TW-1:0]        tk_n;
    logic [6:0]           s_wide;
    logic                 miss;
    logic [2:0]           below;
    logic [2:0]           above;
    logic                 in_all;
    logic [2:0]           cap_idx;
    logic [2:0]           mk;
    logic [2:0]           ak;
    logic signed [37:0]   mul_a;
    logic signed [18:0]   mul_b;
    logic [16:0]          dd;
    logic signed [18:0]   wb;
    logic signed [57:0]   blend;

    ctgs_ram #(
        .WIDTH (32),
        .DEPTH (STORE)
    ) u_vox_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (q_head.load_value),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    ctgs_ram #(
        .WIDTH (SLW),
        .DEPTH (MAX_DOMAINS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (s_reg),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign out_valid   = ov_reg;
    assign field_value = ofv_reg;
    assign slot_used   = osl_reg;
    assign inside_grid = oin_reg;
    assign vox_waddr   = AW'(q_head.load_index);
    assign slot_wdata  = '{in_grid: inside_reg, low: low_reg, high: high_reg,
                           corner: corner_reg};
    assign slot_we     = (state_reg == B_WRITE);
    assign vox_raddr   = ofs_reg + (cnt_reg[0] ? AW'(1) : AW'(0))
                       + (cnt_reg[1] ? DY : AW'(0)) + (cnt_reg[2] ? DZ : AW'(0));
    assign cap_idx     = 3'(cnt_reg - 4'd1);
    assign mk          = 3'(cnt_reg - 4'd3);
    assign ak          = 3'(cnt_reg - 4'd4);
    assign blend       = {bl_reg[56], bl_reg} + {prod_reg[56], prod_reg};
    assign ent         = filled_reg[s_reg] ? ctgs_slot_t'(slot_rdata) : '0;

    always_comb
    begin
        tk_n = (taken_reg < TW'(MAX_DOMAINS)) ? taken_reg + 1'b1 : taken_reg;
        if (q_head.new_domain)
            s_wide = 7'(tk_n) - 7'd1;
        else if ({4'b0, q_head.slot} >= 7'(MAX_DOMAINS))
            s_wide = 7'(MAX_DOMAINS - 1);
        else
            s_wide = {4'b0, q_head.slot};
        slot_raddr = s_wide[SW-1:0];
        q_pop      = (state_reg == B_IDLE) && !q_empty;
        vox_we     = q_pop && (q_head.cmd == CMD_LOAD)
                   && ({14'b0, q_head.load_index} < 32'(STORE));
    end

    always_comb
    begin
        miss = job_reg.new_domain;
        for (int d = 0; d < 3; d++)
        begin
            if ($signed(job_reg.u[d]) < $signed(ent.low[d])
                || $signed(job_reg.u[d]) > $signed(ent.high[d]))
                miss = 1'b1;
            below[d] = job_reg.u[d][31];
            above[d] = !job_reg.u[d][31] && ($signed(job_reg.u[d]) >= TOP[d]);
        end
        in_all = ~|below && ~|above;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority if (cnt_reg == 4'd1)
        begin
            mul_a = 38'(w_reg[0]);
            mul_b = 19'(w_reg[1]);
        end
        else if (cnt_reg >= 4'd3 && cnt_reg <= 4'd10)
        begin
            mul_a = 38'($signed(corner_reg[mk]));
            mul_b = wt_reg[mk[1:0]];
        end
        else if (cnt_reg == 4'd11)
        begin
            mul_a = acc_reg[0][53:16];
            mul_b = 19'sd65536 - 19'(w_reg[2]);
        end
        else if (cnt_reg == 4'd12)
        begin
            mul_a = acc_reg[1][53:16];
            mul_b = 19'(w_reg[2]);
        end
        dd = 17'(prod_reg[32:16]);
        wb = 19'(w_reg[0]) - 19'(dd);
    end

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        s_next      = s_reg;
        s3_next     = s3_reg;
        taken_next  = taken_reg;
        filled_next = filled_reg;
        inside_next = inside_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        corner_next = corner_reg;
        vox_next    = vox_reg;
        mid_next    = mid_reg;
        ofs_next    = ofs_reg;
        cnt_next    = cnt_reg;
        w_next      = w_reg;
        wt_next     = wt_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        bl_next     = bl_reg;
        res_next    = res_reg;
        ov_next     = ov_reg && out_stall;
        ofv_next    = ofv_reg;
        osl_next    = osl_reg;
        oin_next    = oin_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && q_head.cmd == CMD_QUERY)
                begin
                    job_next = q_head;
                    s_next   = s_wide[SW-1:0];
                    s3_next  = s_wide[2:0];
                    if (q_head.new_domain)
                        taken_next = tk_n;
                    state_next = B_LOOK;
                end
            end
            B_LOOK:
            begin
                inside_next = ent.in_grid;
                low_next    = ent.low;
                high_next   = ent.high;
                corner_next = ent.corner;
                cnt_next    = '0;
                if (miss)
                begin
                    inside_next = in_all;
                    for (int d = 0; d < 3; d++)
                    begin
                        if (in_all)
                        begin
                            low_next[d]  = {job_reg.u[d][31:16], 16'b0};
                            high_next[d] = {job_reg.u[d][31:16], 16'b0} + 32'd65536;
                        end
                        else if (below[d])
                        begin
                            low_next[d]  = SMIN;
                            high_next[d] = '0;
                        end
                        else if (above[d])
                        begin
                            low_next[d]  = TOP[d];
                            high_next[d] = SMAX;
                        end
                        else
                        begin
                            low_next[d]  = SMIN;
                            high_next[d] = SMAX;
                        end
                        if (below[d])
                            vox_next[d] = '0;
                        else if (above[d])
                            vox_next[d] = VTOP[d];
                        else
                            vox_next[d] = job_reg.u[d][16 +: VMW];
                    end
                    state_next = B_ADDR;
                end
                else if (ent.in_grid)
                begin
                    state_next = B_MUL;
                end
                else
                begin
                    res_next   = ent.corner[0];
                    state_next = B_DONE;
                end
            end
            B_ADDR:
            begin
                mid_next   = AW'(vox_reg[1]) + AW'(GRID_Y) * AW'(vox_reg[2]);
                state_next = B_OFS;
            end
            B_OFS:
            begin
                ofs_next   = AW'(vox_reg[0]) + AW'(GRID_X) * mid_reg;
                cnt_next   = '0;
                state_next = B_READ;
            end
            B_READ:
            begin
                if (cnt_reg != 4'd0)
                begin
                    if (inside_reg)
                        corner_next[cap_idx] = vox_rdata;
                    else
                        corner_next[0] = ctgs_sat32({{26{vox_rdata[31]}}, vox_rdata}
                                                    + {27'b0, bias});
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == (inside_reg ? 4'd8 : 4'd1))
                begin
                    state_next = B_WRITE;
                end
            end
            B_WRITE:
            begin
                filled_next[s_reg] = 1'b1;
                cnt_next           = '0;
                if (inside_reg)
                begin
                    state_next = B_MUL;
                end
                else
                begin
                    res_next   = corner_reg[0];
                    state_next = B_DONE;
                end
            end
            B_MUL:
            begin
                cnt_next  = cnt_reg + 4'd1;
                prod_next = mul_a * mul_b;
                if (cnt_reg == 4'd0)
                begin
                    for (int d = 0; d < 3; d++)
                    begin
                        w_next[d] = 17'(job_reg.u[d] - low_reg[d]);
                    end
                end
                if (cnt_reg == 4'd2)
                begin
                    wt_next[3] = 19'(dd);
                    wt_next[1] = wb;
                    wt_next[2] = 19'(w_reg[1]) - 19'(dd);
                    wt_next[0] = 19'sd65536 - 19'(w_reg[1]) - wb;
                    acc_next[0] = '0;
                    acc_next[1] = '0;
                end
                if (cnt_reg >= 4'd4 && cnt_reg <= 4'd11)
                begin
                    acc_next[ak[2]] = acc_reg[ak[2]] + prod_reg[53:0];
                end
                if (cnt_reg == 4'd12)
                begin
                    bl_next = prod_reg;
                end
                if (cnt_reg == 4'd13)
                begin
                    res_next   = ctgs_sat32(blend >>> 16);
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ofv_next   = res_reg;
                    osl_next   = s3_reg;
                    oin_next   = inside_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            taken_reg  <= '0;
            filled_reg <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            taken_reg  <= taken_next;
            filled_reg <= filled_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        s_reg      <= s_next;
        s3_reg     <= s3_next;
        inside_reg <= inside_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        corner_reg <= corner_next;
        vox_reg    <= vox_next;
        mid_reg    <= mid_next;
        ofs_reg    <= ofs_next;
        w_reg      <= w_next;
        wt_reg     <= wt_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        bl_reg     <= bl_next;
        res_reg    <= res_next;
        ofv_reg    <= ofv_next;
        osl_reg    <= osl_next;
        oin_reg    <= oin_next;
    end
endmodule

// ===== design/cached_trilinear_grid_sampler_unit.sv =====
// Samples a scalar voxel grid at a point with trilinear blending, using a small
// per-domain cache of the current cell. A load is written to the voxel memory as the
// back part pops it; a query that hits its cached cell inside the grid is blended on
// the single shared multiplier of the blend; a miss adds the eight corner reads inside
// the grid, or a single read outside it, through the one voxel memory read port. The
// front maps the point to grid units and overlaps the back part through a two-item
// queue. Results appear in order, one per query and none per load.
// Top level: ties ctgs_front, ctgs_fifo and ctgs_back; depends on ctgs_pkg.
module cached_trilinear_grid_sampler_unit #(
    parameter int GRID_X      = ctgs_pkg::GRID_X_DEF,
    parameter int GRID_Y      = ctgs_pkg::GRID_Y_DEF,
    parameter int GRID_Z      = ctgs_pkg::GRID_Z_DEF,
    parameter int MAX_DOMAINS = ctgs_pkg::MAX_DOMAINS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [17:0]        load_index,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               new_domain,
    input  logic [2:0]         slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] field_value,
    output logic [2:0]         slot_used,
    output logic               inside_grid
);
    import ctgs_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    ctgs_job_t   q_job;
    ctgs_job_t   q_head;
    logic [30:0] bias;

    ctgs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .load_index (load_index),
        .load_value (load_value),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .new_domain (new_domain),
        .slot       (slot),
        .bias       (bias),
        .q_push     (q_push),
        .q_job      (q_job),
        .q_full     (q_full)
    );

    ctgs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    ctgs_back #(
        .GRID_X      (GRID_X),
        .GRID_Y      (GRID_Y),
        .GRID_Z      (GRID_Z),
        .MAX_DOMAINS (MAX_DOMAINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_head      (q_head),
        .bias        (bias),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .field_value (field_value),
        .slot_used   (slot_used),
        .inside_grid (inside_grid)
    );
endmodule

// ===== design/ctgs_checker.sv =====
// Port-level checker for the cached trilinear grid sampler, bound to the top level.
// Depends on cached_trilinear_grid_sampler_unit_macros.svh.
`include "cached_trilinear_grid_sampler_unit_macros.svh"

module ctgs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        cmd,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] field_value,
    input logic [2:0]  slot_used,
    input logic        inside_grid
);
    logic [3:0] pend_reg, pend_next;
    logic       q_acc;
    logic       o_acc;

    assign q_acc = in_valid && !in_stall && cmd;
    assign o_acc = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg + (q_acc ? 4'd1 : 4'd0) - (o_acc ? 4'd1 : 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `CTGS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(field_value) && $stable(slot_used) && $stable(inside_grid))
    `CTGS_ASSERT_NOW(a_no_extra_result, clk, rst_n, out_valid, pend_reg != 4'd0)
    `CTGS_ASSERT_NOW(a_inflight_bound, clk, rst_n, 1'b1, pend_reg <= 4'd5)
    `CTGS_ASSERT_NOW(a_stall_after_take, clk, rst_n, $rose(in_stall), $past(in_valid))
endmodule

bind cached_trilinear_grid_sampler_unit ctgs_checker u_ctgs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_value (field_value),
    .slot_used   (slot_used),
    .inside_grid (inside_grid)
);
